FILE: hw/rtl/nkps_pkg.sv
// shared types and constants of the nearest-k point selector
package nkps_pkg;

   localparam int CSR_DATA_BITS   = 41;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int DIST_OUT_BITS   = 41;
   localparam int FREE_SLOTS_BITS = 5;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ENABLE         = 3'd0,
      CSR_REF_X          = 3'd1,
      CSR_REF_Y          = 3'd2,
      CSR_RADIUS_SQUARED = 3'd3,
      CSR_FREE_SLOTS     = 3'd4
   } csr_index_type;

   // control that travels with a point down the distance pipeline
   typedef struct packed {
      logic valid;
      logic keep;
      logic last;
   } point_ctl_type;

   // per-cycle command to the sorted cell row
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctl_type;

endpackage

FILE: hw/rtl/nkps_if.sv
// item channels of the nearest-k point selector
interface nkps_req_if #(parameter int COORD_BITS = 20) ();
   logic                         valid;
   logic                         ready;
   logic                         selectable;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic                         last_point;

   modport source (output valid, selectable, point_x, point_y, last_point, input ready);
   modport sink   (input valid, selectable, point_x, point_y, last_point, output ready);
endinterface

interface nkps_rsp_if import nkps_pkg::*; #(parameter int COORD_BITS = 20) ();
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic signed [COORD_BITS-1:0] out_x;
   logic signed [COORD_BITS-1:0] out_y;
   logic [DIST_OUT_BITS-1:0]     out_dist_sq;
   logic                         last_result;

   modport source (output valid, found, out_x, out_y, out_dist_sq, last_result, input ready);
   modport sink   (input valid, found, out_x, out_y, out_dist_sq, last_result, output ready);
endinterface

FILE: hw/rtl/nkps_dist.sv
// three-stage squared distance and radius check
module nkps_dist import nkps_pkg::*; #(
   parameter int COORD_BITS = 20
) (
   input  logic                         clock,
   input  logic                         reset,
   input  point_ctl_type                in_ctl,
   input  logic signed [COORD_BITS-1:0] point_x,
   input  logic signed [COORD_BITS-1:0] point_y,
   input  logic signed [COORD_BITS-1:0] ref_x,
   input  logic signed [COORD_BITS-1:0] ref_y,
   input  logic                         enable,
   input  logic [DIST_OUT_BITS-1:0]     radius_squared,
   output point_ctl_type                out_ctl,
   output logic [2*COORD_BITS+1:0]      out_dist,
   output logic [2*COORD_BITS-1:0]      out_pos
);

   localparam int DW = 2 * COORD_BITS + 2;
   localparam int SQ = 2 * COORD_BITS + 1;
   localparam int PW = 2 * COORD_BITS;
   localparam int CW = (DW > DIST_OUT_BITS) ? DW : DIST_OUT_BITS;

   point_ctl_type           ctl1_ff, ctl1_in, ctl2_ff, ctl2_in, ctl3_ff, ctl3_in;
   logic signed [COORD_BITS:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [PW-1:0]           pos1_ff, pos2_ff, pos3_ff;
   logic [SQ-1:0]           sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [DW-1:0]           dist_ff, dist_in;
   logic signed [2*COORD_BITS+1:0] prod_x, prod_y;

   always_comb begin
      // stage 1: signed differences
      ctl1_in = in_ctl;
      dx_in   = $signed({point_x[COORD_BITS-1], point_x}) - $signed({ref_x[COORD_BITS-1], ref_x});
      dy_in   = $signed({point_y[COORD_BITS-1], point_y}) - $signed({ref_y[COORD_BITS-1], ref_y});
      // stage 2: squares, always non-negative
      prod_x  = dx_ff * dx_ff;
      prod_y  = dy_ff * dy_ff;
      sqx_in  = prod_x[SQ-1:0];
      sqy_in  = prod_y[SQ-1:0];
      ctl2_in = ctl1_ff;
      // stage 3: sum and inclusive radius check
      dist_in      = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      ctl3_in      = ctl2_ff;
      ctl3_in.keep = ctl2_ff.valid & ctl2_ff.keep & enable &
                     (CW'(dist_in) <= CW'(radius_squared));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl2_in;
         ctl3_ff <= ctl3_in;
      end
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      pos1_ff <= {point_y, point_x};
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
      pos2_ff <= pos1_ff;
      dist_ff <= dist_in;
      pos3_ff <= pos2_ff;
   end

   assign out_ctl  = ctl3_ff;
   assign out_dist = dist_ff;
   assign out_pos  = pos3_ff;

endmodule

FILE: hw/rtl/nkps_cell.sv
// one slot of the sorted list: insert from the left, drain to the left
module nkps_cell import nkps_pkg::*; #(
   parameter int COORD_BITS = 20
) (
   input  logic                        clock,
   input  cell_ctl_type                ctl,
   input  logic                        occupied,
   input  logic [2*COORD_BITS+1:0]     new_dist,
   input  logic [2*COORD_BITS-1:0]     new_pos,
   input  logic                        left_ins,
   input  logic [2*COORD_BITS+1:0]     left_dist,
   input  logic [2*COORD_BITS-1:0]     left_pos,
   input  logic [2*COORD_BITS+1:0]     right_dist,
   input  logic [2*COORD_BITS-1:0]     right_pos,
   output logic                        ins,
   output logic [2*COORD_BITS+1:0]     slot_dist,
   output logic [2*COORD_BITS-1:0]     pos
);

   logic [2*COORD_BITS+1:0] dist_ff, dist_in;
   logic [2*COORD_BITS-1:0] pos_ff, pos_in;

   // new point belongs at or before this slot
   assign ins = !occupied || (dist_ff > new_dist);

   always_comb begin
      dist_in = dist_ff;
      pos_in  = pos_ff;
      if (ctl.insert) begin
         if (left_ins) begin
            dist_in = left_dist;
            pos_in  = left_pos;
         end else if (ins) begin
            dist_in = new_dist;
            pos_in  = new_pos;
         end
      end else if (ctl.shift) begin
         dist_in = right_dist;
         pos_in  = right_pos;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      pos_ff  <= pos_in;
   end

   assign slot_dist = dist_ff;
   assign pos       = pos_ff;

endmodule

FILE: hw/rtl/nearest_k_point_selector_unit.sv
// top level of the nearest-k point selector
//
// usage
//   - program enable, ref_x, ref_y, radius_squared and free_slots over the csr_ write port
//     while the block is idle; a write lands at the clock edge where csr_write_enable is high
//   - stream a pass of points on req_if, last_point set on the final one; valid/ready handshake
//   - within a pass one point is taken per cycle: a three-stage distance pipeline
//     (difference, square, sum and radius check) feeds a row of MAX_KEPT sorted cells,
//     and each qualifying point is inserted straight into its sorted place in the row
//   - req_if.ready drops once the last point is taken and rises again when the final
//     result of the pass has been loaded into the output register, or when a pass without results ends
//   - results leave on rsp_if nearest first, last_result on the final one; the first result
//     is registered after the last point has left the distance pipeline and passed ST_FINISH,
//     then one per cycle as the row shifts toward the output while rsp_if.ready is high
//   - a pass with no qualifying point gives one result with found low; a pass with enable or
//     free_slots at zero gives no result
//   - a stalled receiver holds the output register and the row; the next pass may start
//     while the final result still waits
//   - synchronous reset clears the configuration, the list and the handshake state
module nearest_k_point_selector_unit import nkps_pkg::*; #(
   parameter int MAX_KEPT   = 16,
   parameter int COORD_BITS = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   nkps_req_if.sink                  req_if,
   nkps_rsp_if.source                rsp_if,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int DW       = 2 * COORD_BITS + 2;
   localparam int PW       = 2 * COORD_BITS;
   localparam int CNT_BITS = $clog2(MAX_KEPT + 1);
   localparam int SW       = (CNT_BITS > FREE_SLOTS_BITS) ? CNT_BITS : FREE_SLOTS_BITS;
   localparam int CW       = (DW > DIST_OUT_BITS) ? DW : DIST_OUT_BITS;
   localparam logic [DIST_OUT_BITS-1:0] DIST_MAX = {DIST_OUT_BITS{1'b1}};

   typedef enum logic [1:0] {
      ST_RUN,     // taking points
      ST_FLUSH,   // last point still in the distance pipeline
      ST_FINISH,  // list complete, work out how many results
      ST_DRAIN    // unloading results
   } state_type;

   // configuration registers
   logic                         enable_ff, enable_in;
   logic signed [COORD_BITS-1:0] ref_x_ff, ref_x_in, ref_y_ff, ref_y_in;
   logic [DIST_OUT_BITS-1:0]     radius_ff, radius_in;
   logic [FREE_SLOTS_BITS-1:0]   free_slots_ff, free_slots_in;

   // control
   state_type                    state_ff, state_in;
   logic [CNT_BITS-1:0]          count_ff, count_in;
   logic [CNT_BITS-1:0]          left_ff, left_in;
   logic                         none_ff, none_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [DIST_OUT_BITS-1:0]     rsp_dist_ff, rsp_dist_in;
   logic                         rsp_last_ff, rsp_last_in;

   // pipeline and cell row
   point_ctl_type                req_ctl, s3_ctl;
   logic [DW-1:0]                s3_dist;
   logic [PW-1:0]                s3_pos;
   cell_ctl_type                 cell_ctl;
   logic                         shift_go;
   logic [DW-1:0]                cell_dist [MAX_KEPT];
   logic [PW-1:0]                cell_pos  [MAX_KEPT];
   logic                         cell_ins  [MAX_KEPT];

   logic                         out_free;
   logic [SW-1:0]                slots;
   logic [CNT_BITS-1:0]          n_results;
   logic [CW-1:0]                head_dist;

   // configuration writes
   always_comb begin
      enable_in     = enable_ff;
      ref_x_in      = ref_x_ff;
      ref_y_in      = ref_y_ff;
      radius_in     = radius_ff;
      free_slots_in = free_slots_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENABLE:         enable_in     = csr_write_data[0];
            CSR_REF_X:          ref_x_in      = csr_write_data[COORD_BITS-1:0];
            CSR_REF_Y:          ref_y_in      = csr_write_data[COORD_BITS-1:0];
            CSR_RADIUS_SQUARED: radius_in     = csr_write_data[DIST_OUT_BITS-1:0];
            CSR_FREE_SLOTS:     free_slots_in = csr_write_data[FREE_SLOTS_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         ref_x_ff      <= '0;
         ref_y_ff      <= '0;
         radius_ff     <= '0;
         free_slots_ff <= '0;
      end else begin
         enable_ff     <= enable_in;
         ref_x_ff      <= ref_x_in;
         ref_y_ff      <= ref_y_in;
         radius_ff     <= radius_in;
         free_slots_ff <= free_slots_in;
      end
   end

   // input side
   assign req_if.ready     = (state_ff == ST_RUN);
   assign req_ctl.valid    = req_if.valid && req_if.ready;
   assign req_ctl.keep     = req_if.selectable;
   assign req_ctl.last     = req_if.last_point;

   nkps_dist #(
      .COORD_BITS (COORD_BITS)
   ) u_dist (
      .clock          (clock),
      .reset          (reset),
      .in_ctl         (req_ctl),
      .point_x        (req_if.point_x),
      .point_y        (req_if.point_y),
      .ref_x          (ref_x_ff),
      .ref_y          (ref_y_ff),
      .enable         (enable_ff),
      .radius_squared (radius_ff),
      .out_ctl        (s3_ctl),
      .out_dist       (s3_dist),
      .out_pos        (s3_pos)
   );

   // sorted row: slot 0 holds the nearest point, slots below count_ff are occupied
   assign cell_ctl.insert = s3_ctl.valid && s3_ctl.keep;
   assign cell_ctl.shift  = shift_go;

   for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
      logic          left_ins;
      logic [DW-1:0] left_dist, right_dist;
      logic [PW-1:0] left_pos, right_pos;

      if (i == 0) begin : g_head
         assign left_ins  = 1'b0;
         assign left_dist = s3_dist;
         assign left_pos  = s3_pos;
      end else begin : g_body
         assign left_ins  = cell_ins[i-1];
         assign left_dist = cell_dist[i-1];
         assign left_pos  = cell_pos[i-1];
      end

      if (i == MAX_KEPT - 1) begin : g_tail
         assign right_dist = cell_dist[i];
         assign right_pos  = cell_pos[i];
      end else begin : g_inner
         assign right_dist = cell_dist[i+1];
         assign right_pos  = cell_pos[i+1];
      end

      nkps_cell #(
         .COORD_BITS (COORD_BITS)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .occupied   (count_ff > CNT_BITS'(i)),
         .new_dist   (s3_dist),
         .new_pos    (s3_pos),
         .left_ins   (left_ins),
         .left_dist  (left_dist),
         .left_pos   (left_pos),
         .right_dist (right_dist),
         .right_pos  (right_pos),
         .ins        (cell_ins[i]),
         .slot_dist  (cell_dist[i]),
         .pos        (cell_pos[i])
      );
   end

   // results allowed this pass: free_slots capped at the row length
   assign slots     = (SW'(free_slots_ff) > SW'(MAX_KEPT)) ? SW'(MAX_KEPT) : SW'(free_slots_ff);
   assign n_results = (SW'(count_ff) < slots) ? count_ff : CNT_BITS'(slots);
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign head_dist = CW'(cell_dist[0]);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      left_in      = left_ff;
      none_in      = none_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_last_in  = rsp_last_ff;
      shift_go     = 1'b0;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      // a full row keeps its count, the farthest entry falls off the end
      if (cell_ctl.insert && (count_ff < CNT_BITS'(MAX_KEPT))) begin
         count_in = count_ff + CNT_BITS'(1);
      end

      unique case (state_ff)
         ST_RUN: begin
            if (req_if.valid && req_if.ready && req_if.last_point) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // the last point leaves the distance pipeline in this cycle and, if kept, is placed into the row
            if (s3_ctl.valid && s3_ctl.last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!enable_ff || (slots == '0)) begin
               count_in = '0;
               state_in = ST_RUN;
            end else begin
               left_in  = n_results;
               none_in  = (n_results == '0);
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (none_ff) begin
                  // nothing qualified
                  rsp_found_in = 1'b0;
                  rsp_x_in     = '0;
                  rsp_y_in     = '0;
                  rsp_dist_in  = '0;
                  rsp_last_in  = 1'b1;
                  count_in     = '0;
                  state_in     = ST_RUN;
               end else begin
                  rsp_found_in = 1'b1;
                  rsp_x_in     = cell_pos[0][COORD_BITS-1:0];
                  rsp_y_in     = cell_pos[0][PW-1:COORD_BITS];
                  rsp_dist_in  = (head_dist > CW'(DIST_MAX)) ? DIST_MAX
                                                             : head_dist[DIST_OUT_BITS-1:0];
                  rsp_last_in  = (left_ff == CNT_BITS'(1));
                  shift_go     = 1'b1;
                  left_in      = left_ff - CNT_BITS'(1);
                  if (left_ff == CNT_BITS'(1)) begin
                     count_in = '0;
                     state_in = ST_RUN;
                  end
               end
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         count_ff     <= '0;
         left_ff      <= '0;
         none_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         none_ff      <= none_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_found_ff <= rsp_found_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // output side
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.found       = rsp_found_ff;
   assign rsp_if.out_x       = rsp_x_ff;
   assign rsp_if.out_y       = rsp_y_ff;
   assign rsp_if.out_dist_sq = rsp_dist_ff;
   assign rsp_if.last_result = rsp_last_ff;

endmodule

FILE: tb/nearest_k_point_selector_unit_test.sv
// testbench of the nearest-k point selector: directed and random passes against a sorted list
module nearest_k_point_selector_unit_test import nkps_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     COORD_BITS     = 20;
   localparam int     MAX_KEPT       = 16;
   localparam int     CLOCK_PERIOD   = 20;
   localparam int     RESET_CYCLES   = 5;
   // the first result follows the last point through the distance pipeline, then up to 15 more; keep a margin
   localparam int     SETTLE_CYCLES  = 40;
   localparam int     STALL_LIMIT    = 3000;
   localparam int     HOLDOFF_CYCLES = 300;
   localparam int     PHASE_ITEMS    = 42;
   localparam int     MAX_GAP        = 20;
   localparam longint RADIUS_MAX     = (longint'(1) << DIST_OUT_BITS) - 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [DIST_OUT_BITS-1:0]     dist_type;

   // one point of a pass
   typedef struct {
      logic      selectable;
      coord_type x;
      coord_type y;
      logic      last;
   } point_item_type;

   // one selected neighbor as it should leave the block
   typedef struct {
      logic      found;
      coord_type x;
      coord_type y;
      dist_type  dist_sq;
      logic      last;
   } neighbor_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   nkps_req_if #(.COORD_BITS(COORD_BITS)) req_bus ();
   nkps_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_bus ();

   nearest_k_point_selector_unit #(
      .MAX_KEPT  (MAX_KEPT),
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_bus),
      .rsp_if          (rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   // mirror of the configuration registers, all zero after reset
   logic      cfg_enable = 1'b0;
   coord_type cfg_ref_x  = '0;
   coord_type cfg_ref_y  = '0;
   longint    cfg_radius = 0;
   int        cfg_slots  = 0;

   // nearest candidates of the current pass, sorted by distance, ties in arrival order
   longint    near_dist [MAX_KEPT];
   coord_type near_x    [MAX_KEPT];
   coord_type near_y    [MAX_KEPT];
   int        near_count = 0;

   // neighbors that the block still owes, oldest first
   neighbor_type pending_neighbors [$];

   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int holdoff_request = 0;
   int error_count     = 0;
   int points_sent     = 0;
   int quiet_cycles    = 0;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // exact squared distance to the reference point, a plain integer
   function automatic longint squared_range(coord_type x, coord_type y);
      longint dx, dy;
      dx = longint'(x) - longint'(cfg_ref_x);
      dy = longint'(y) - longint'(cfg_ref_y);
      return dx * dx + dy * dy;
   endfunction

   // fold one accepted point into the sorted list; on the last point queue what the pass emits
   function automatic void fold_point(point_item_type p);
      longint       d;
      int           slot, i, n, slots;
      neighbor_type r;
      d = squared_range(p.x, p.y);
      if (cfg_enable && p.selectable && d <= cfg_radius) begin
         // goes before the first entry that is strictly farther
         slot = 0;
         while (slot < near_count && near_dist[slot] <= d) slot++;
         if (slot < MAX_KEPT) begin
            // a full list drops its farthest entry
            for (i = (near_count < MAX_KEPT) ? near_count : MAX_KEPT - 1; i > slot; i--) begin
               near_dist[i] = near_dist[i-1];
               near_x[i]    = near_x[i-1];
               near_y[i]    = near_y[i-1];
            end
            near_dist[slot] = d;
            near_x[slot]    = p.x;
            near_y[slot]    = p.y;
            if (near_count < MAX_KEPT) near_count++;
         end
      end
      if (p.last) begin
         // more free slots than cells act as all cells
         slots = (cfg_slots > MAX_KEPT) ? MAX_KEPT : cfg_slots;
         n     = (near_count < slots) ? near_count : slots;
         // disabled or no free slots: the pass emits nothing
         if (cfg_enable && slots > 0) begin
            if (n == 0) begin
               // nothing qualified: one empty result
               r.found   = 1'b0;
               r.x       = '0;
               r.y       = '0;
               r.dist_sq = '0;
               r.last    = 1'b1;
               pending_neighbors = {pending_neighbors, r};
            end else begin
               for (i = 0; i < n; i++) begin
                  r.found   = 1'b1;
                  r.x       = near_x[i];
                  r.y       = near_y[i];
                  r.dist_sq = dist_type'(near_dist[i]);
                  r.last    = (i == n - 1);
                  pending_neighbors = {pending_neighbors, r};
               end
            end
         end
         near_count = 0;
      end
   endfunction

   // offer one point until it is taken, then maybe leave the channel idle for a while
   task automatic send_point(input point_item_type p);
      int gap;
      req_bus.valid      <= 1'b1;
      req_bus.selectable <= p.selectable;
      req_bus.point_x    <= p.x;
      req_bus.point_y    <= p.y;
      req_bus.last_point <= p.last;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      fold_point(p);
      points_sent++;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_at(input logic sel, input int x, input int y, input logic last);
      point_item_type p;
      p.selectable = sel;
      p.x          = coord_type'(x);
      p.y          = coord_type'(y);
      p.last       = last;
      send_point(p);
   endtask

   // stop offering, wait for every owed neighbor, then let a pass without results finish
   task automatic settle_block();
      req_bus.valid <= 1'b0;
      while (pending_neighbors.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   // all five registers, written back to back once the block is idle
   task automatic program_selector(input logic en, input int rx, input int ry,
                                   input longint r2, input int slots);
      settle_block();
      write_reg(CSR_ENABLE, CSR_DATA_BITS'(en));
      write_reg(CSR_REF_X, CSR_DATA_BITS'(coord_type'(rx)));
      write_reg(CSR_REF_Y, CSR_DATA_BITS'(coord_type'(ry)));
      write_reg(CSR_RADIUS_SQUARED, CSR_DATA_BITS'(r2));
      write_reg(CSR_FREE_SLOTS, CSR_DATA_BITS'(slots));
      csr_write_enable <= 1'b0;
      cfg_enable = en;
      cfg_ref_x  = coord_type'(rx);
      cfg_ref_y  = coord_type'(ry);
      cfg_radius = r2 & RADIUS_MAX;
      cfg_slots  = slots & ((1 << FREE_SLOTS_BITS) - 1);
   endtask

   // random setting; span is the spread of points around the reference that suits the radius
   task automatic program_random_selector(output int span);
      int     pick, slots, rx, ry;
      longint r2;
      logic   en;
      int     spans [4] = '{3, 200, 40000, 524287};
      span = spans[$urandom_range(3)];
      en   = ($urandom_range(9) != 0);
      pick = $urandom_range(99);
      if (pick < 10) begin
         rx = pick[0] ? -524288 : 524287;
         ry = pick[1] ? -524288 : 524287;
      end else begin
         rx = int'(coord_type'($urandom));
         ry = int'(coord_type'($urandom));
      end
      pick = $urandom_range(99);
      if (pick < 5)       r2 = 0;
      else if (pick < 12) r2 = RADIUS_MAX;
      else                r2 = (longint'(span) * span * $urandom_range(0, 200)) / 100;
      pick = $urandom_range(99);
      if (pick < 10)      slots = 0;
      else if (pick < 20) slots = $urandom_range(MAX_KEPT + 1, 31);
      else                slots = $urandom_range(1, MAX_KEPT);
      program_selector(en, rx, ry, r2, slots);
   endtask

   // one pass: mostly points near the reference, mirrored ones for equal distances, some anywhere
   task automatic send_random_pass(input int len, input int span);
      point_item_type p;
      int             k, off_x, off_y, pick;
      off_x = 0;
      off_y = 0;
      for (k = 0; k < len; k++) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            off_x = -off_x;
         end else if (pick < 15) begin
            {off_x, off_y} = {off_y, off_x};
         end else if (pick < 85) begin
            off_x = int'($urandom_range(0, 2 * span)) - span;
            off_y = int'($urandom_range(0, 2 * span)) - span;
         end
         if (pick >= 85) begin
            p.x = coord_type'($urandom);
            p.y = coord_type'($urandom);
         end else begin
            p.x = coord_type'(longint'(cfg_ref_x) + off_x);
            p.y = coord_type'(longint'(cfg_ref_y) + off_y);
         end
         p.selectable = ($urandom_range(99) < 80);
         p.last       = (k == len - 1);
         send_point(p);
      end
   endtask

   // a non-selectable point on the reference and a far one: one empty result
   task automatic test_nothing_found();
      program_selector(1'b1, 0, 0, 100, 4);
      send_at(1'b0, 0, 0, 1'b0);
      send_at(1'b1, 100, 0, 1'b1);
   endtask

   // radius limit is inclusive; equal distances come out in arrival order
   task automatic test_radius_edge_and_ties();
      program_selector(1'b1, 16, -16, 25, MAX_KEPT);
      send_at(1'b1, 19, -12, 1'b0);
      send_at(1'b1, 13, -20, 1'b0);
      send_at(1'b1, 16, -16, 1'b0);
      send_at(1'b1, 19, -11, 1'b0);
      send_at(1'b1, 16, -11, 1'b1);
   endtask

   // corner coordinates with the widest radius, largest possible distance included
   task automatic test_coordinate_extremes();
      program_selector(1'b1, -524288, 524287, RADIUS_MAX, MAX_KEPT);
      send_at(1'b1, 524287, -524288, 1'b0);
      send_at(1'b1, -524288, 524287, 1'b0);
      send_at(1'b0, 0, 0, 1'b0);
      send_at(1'b1, 524287, 524287, 1'b0);
      send_at(1'b1, -524288, -524288, 1'b0);
      send_at(1'b1, -1, -1, 1'b1);
   endtask

   // free slots above the cell count, then fewer slots than candidates
   task automatic test_slot_limits();
      program_selector(1'b1, 0, 0, RADIUS_MAX, 31);
      send_at(1'b1, 5, 5, 1'b0);
      send_at(1'b1, -3, 0, 1'b0);
      send_at(1'b1, 0, 0, 1'b1);
      program_selector(1'b1, 0, 0, RADIUS_MAX, 2);
      send_at(1'b1, 9, 9, 1'b0);
      send_at(1'b1, 1, 1, 1'b0);
      send_at(1'b1, 2, 2, 1'b0);
      send_at(1'b1, 0, 7, 1'b1);
   endtask

   // disabled block and zero free slots both give passes without results
   task automatic test_disabled_and_no_slots();
      program_selector(1'b0, 0, 0, RADIUS_MAX, MAX_KEPT);
      send_at(1'b1, 1, 1, 1'b0);
      send_at(1'b1, 2, 2, 1'b1);
      program_selector(1'b1, 0, 0, RADIUS_MAX, 0);
      send_at(1'b1, 3, 3, 1'b0);
      send_at(1'b1, 4, 4, 1'b1);
   endtask

   // random passes under one idling mix, a fresh setting every third pass
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int item_count);
      int span, stop_at, pass_no, len, pick;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      stop_at        = points_sent + item_count;
      pass_no        = 0;
      span           = 0;
      while (points_sent < stop_at) begin
         if (pass_no % 3 == 0) program_random_selector(span);
         pick = $urandom_range(99);
         // long passes can overflow the list
         if (pick < 70)      len = $urandom_range(1, 12);
         else if (pick < 92) len = $urandom_range(13, 24);
         else                len = 1;
         send_random_pass(len, span);
         pass_no++;
      end
   endtask

   // receiver holds off while passes keep coming, so results back up in the cell row and input stalls
   task automatic test_receiver_holdoff();
      int k;
      program_selector(1'b1, 0, 0, RADIUS_MAX, MAX_KEPT);
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      holdoff_request = HOLDOFF_CYCLES;
      for (k = 0; k < 4; k++) send_random_pass(10, 524287);
   endtask

   // sender waits for every owed neighbor between two passes
   task automatic test_sender_pause();
      program_selector(1'b1, 100, -100, 90000, 8);
      send_idle_pct  = 0;
      recv_stall_pct = 60;
      send_random_pass(8, 200);
      settle_block();
      send_random_pass(8, 200);
   endtask

   // result side: check each taken neighbor, then pick ready for the next edge
   initial begin
      int           holdoff_left;
      neighbor_type want;
      holdoff_left  = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pending_neighbors.size() == 0) begin
               $error("unexpected result: found=%0b x=%0d y=%0d dist=%0d last=%0b",
                      rsp_bus.found, rsp_bus.out_x, rsp_bus.out_y, rsp_bus.out_dist_sq,
                      rsp_bus.last_result);
               error_count++;
            end else begin
               want = pending_neighbors.pop_front();
               if (rsp_bus.found !== want.found) begin
                  $error("found: expected %0b, got %0b", want.found, rsp_bus.found);
                  error_count++;
               end
               if (rsp_bus.out_x !== want.x) begin
                  $error("out_x: expected %0d, got %0d", want.x, rsp_bus.out_x);
                  error_count++;
               end
               if (rsp_bus.out_y !== want.y) begin
                  $error("out_y: expected %0d, got %0d", want.y, rsp_bus.out_y);
                  error_count++;
               end
               if (rsp_bus.out_dist_sq !== want.dist_sq) begin
                  $error("out_dist_sq: expected %0d, got %0d", want.dist_sq,
                         rsp_bus.out_dist_sq);
                  error_count++;
               end
               if (rsp_bus.last_result !== want.last) begin
                  $error("last_result: expected %0b, got %0b", want.last, rsp_bus.last_result);
                  error_count++;
               end
            end
         end
         // a requested hold-off is counted here, cycle by cycle
         if (holdoff_request > 0) begin
            holdoff_left    = holdoff_request;
            holdoff_request = 0;
         end
         if (holdoff_left > 0) begin
            rsp_bus.ready <= 1'b0;
            holdoff_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // watchdog: too long with no item taken on any side ends the run
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset              <= 1'b1;
      csr_write_enable   <= 1'b0;
      csr_index          <= '0;
      csr_write_data     <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.selectable <= 1'b0;
      req_bus.point_x    <= '0;
      req_bus.point_y    <= '0;
      req_bus.last_point <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed part, no idling
      test_nothing_found();
      test_radius_edge_and_ties();
      test_coordinate_extremes();
      test_slot_limits();
      test_disabled_and_no_slots();

      // random part: no idling, idle sender, stalling receiver, both a little
      test_random_traffic(0, 0, PHASE_ITEMS);
      test_random_traffic(60, 0, PHASE_ITEMS);
      test_random_traffic(0, 60, PHASE_ITEMS);
      test_random_traffic(9, 9, PHASE_ITEMS);
      test_receiver_holdoff();
      test_sender_pause();

      settle_block();
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
